>>> sv/smp_pkg.sv
package smp_pkg;

    localparam logic       SMP_CMD_BYTE = 1'b0;
    localparam logic       SMP_CMD_END  = 1'b1;
    localparam logic [7:0] SMP_PAD_BYTE = 8'h80;
    localparam logic [3:0] SMP_LAST_IDX = 4'd15;
    localparam int SMP_QDEPTH = 2;

    typedef struct packed {
        logic        is_pad;
        logic [63:0] word;
        logic [3:0]  index;
        logic        fits;
        logic [63:0] bit_count;
    } smp_job_t;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } bk_state_t;

endpackage

>>> sv/smp_front.sv
module smp_front
    import smp_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           cmd,
    input  logic [7:0]     data_byte,
    input  logic           q_full,
    output logic           push_valid,
    output smp_job_t       push_job
);

    logic [55:0] gather_reg, gather_next;
    logic [6:0]  pos_reg, pos_next;
    logic [63:0] bit_count_reg, bit_count_next;
    logic        accept;
    logic [2:0]  k;
    logic [63:0] g64;
    logic [6:0]  shl_data;
    logic [6:0]  shl_pad;
    logic [63:0] pad_word;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign k        = pos_reg[2:0];
    assign g64      = {8'h00, gather_reg};
    assign shl_data = 7'd64 - {1'b0, k, 3'b000};
    assign shl_pad  = 7'd56 - {1'b0, k, 3'b000};
    assign pad_word = (g64 << shl_data) | ({56'h0, SMP_PAD_BYTE} << shl_pad);

    always_comb
    begin
        gather_next    = gather_reg;
        pos_next       = pos_reg;
        bit_count_next = bit_count_reg;
        push_valid     = 1'b0;
        push_job       = '0;
        if (accept)
        begin
            if (cmd == SMP_CMD_BYTE)
            begin
                bit_count_next = bit_count_reg + 64'd8;
                pos_next       = pos_reg + 7'd1;
                if (k == 3'd7)
                begin
                    push_valid         = 1'b1;
                    push_job.is_pad    = 1'b0;
                    push_job.word      = {gather_reg, data_byte};
                    push_job.index     = pos_reg[6:3];
                    push_job.fits      = 1'b1;
                    push_job.bit_count = bit_count_reg;
                    gather_next        = '0;
                end
                else
                begin
                    gather_next = {gather_reg[47:0], data_byte};
                end
            end
            else
            begin
                push_valid         = 1'b1;
                push_job.is_pad    = 1'b1;
                push_job.word      = pad_word;
                push_job.index     = pos_reg[6:3];
                push_job.fits      = (pos_reg[6:4] != 3'b111);
                push_job.bit_count = bit_count_reg;
                gather_next        = '0;
                pos_next           = '0;
                bit_count_next     = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gather_reg    <= '0;
            pos_reg       <= '0;
            bit_count_reg <= '0;
        end
        else
        begin
            gather_reg    <= gather_next;
            pos_reg       <= pos_next;
            bit_count_reg <= bit_count_next;
        end
    end

endmodule

>>> sv/smp_queue.sv
module smp_queue
    import smp_pkg::*;
#(
    parameter int QDEPTH = SMP_QDEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push_valid,
    input  smp_job_t push_job,
    output logic     full,
    input  logic     pop,
    output smp_job_t pop_job,
    output logic     empty
);

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(QDEPTH - 1);

    smp_job_t         slots_reg [QDEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push_valid && !full;
    assign do_pop  = pop && !empty;
    assign pop_job = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> sv/smp_back.sv
module smp_back
    import smp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  smp_job_t    q_job,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] word,
    output logic [3:0]  word_index,
    output logic        block_done,
    output logic        message_done,
    output logic        last
);

    bk_state_t   state_reg, state_next;
    smp_job_t    job_reg, job_next;
    logic [3:0]  idx_reg, idx_next;
    logic        second_reg, second_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] word_reg, word_next;
    logic [3:0]  index_reg, index_next;
    logic        md_reg, md_next;
    logic        last_reg, last_next;
    logic        emit;
    logic [63:0] v;
    logic        fin;

    always_comb
    begin
        if (!job_reg.is_pad)
        begin
            v   = job_reg.word;
            fin = 1'b1;
        end
        else if (second_reg)
        begin
            fin = (idx_reg == SMP_LAST_IDX);
            v   = fin ? job_reg.bit_count : '0;
        end
        else if (job_reg.fits && idx_reg == SMP_LAST_IDX)
        begin
            v   = job_reg.bit_count;
            fin = 1'b1;
        end
        else
        begin
            v   = (idx_reg == job_reg.index) ? job_reg.word : '0;
            fin = 1'b0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        idx_next       = idx_reg;
        second_next    = second_reg;
        out_valid_next = out_valid_reg;
        word_next      = word_reg;
        index_next     = index_reg;
        md_next        = md_reg;
        last_next      = last_reg;
        pop            = 1'b0;
        emit           = 1'b0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    pop         = 1'b1;
                    job_next    = q_job;
                    idx_next    = q_job.index;
                    second_next = 1'b0;
                    state_next  = BK_RUN;
                end
            end
            BK_RUN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    emit           = 1'b1;
                    out_valid_next = 1'b1;
                    word_next      = v;
                    index_next     = idx_reg;
                    md_next        = job_reg.is_pad && fin;
                    last_next      = fin;
                    if (fin)
                    begin
                        state_next = BK_IDLE;
                    end
                    else if (idx_reg == SMP_LAST_IDX)
                    begin
                        second_next = 1'b1;
                        idx_next    = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 4'd1;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            second_reg    <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg   <= job_next;
        idx_reg   <= idx_next;
        word_reg  <= word_next;
        index_reg <= index_next;
        md_reg    <= md_next;
        last_reg  <= last_next;
    end

    assign out_valid    = out_valid_reg;
    assign word         = word_reg;
    assign word_index   = index_reg;
    assign block_done   = (index_reg == SMP_LAST_IDX);
    assign message_done = md_reg;
    assign last         = last_reg;

`ifndef SYNTHESIS
    a_pop_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg == BK_RUN))
        else $error("job popped but sequencer did not start");

    a_second_only_pad: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_RUN && second_reg) |-> (job_reg.is_pad && !job_reg.fits))
        else $error("second padding block on a job that does not need one");

    a_done_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && md_reg) |-> (last_reg && index_reg == SMP_LAST_IDX))
        else $error("message end not on the last word of a block");

    a_emit_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> out_valid_reg)
        else $error("emitted word was not presented");
`endif

endmodule

>>> sv/sha512_message_padder_unit.sv
// SHA-512 message padder.
// The input channel (in_valid, in_ready) takes one item at a time: cmd 0 with a
// message byte in data_byte, or cmd 1 to close the message.
// The output channel (out_valid, out_ready) delivers 64-bit big-endian block
// words with word_index, block_done, message_done and last.
// Every eighth byte yields one word, passed through the job queue and the
// job register into the output register. The end command yields the padding
// run: the rest of the block, and a second block when 112 or more bytes were
// in the current block, one word per cycle while the receiver takes them, so
// up to 18 words. The sequencer picks up each new job while idle.
// Bytes are accepted one per cycle while the job queue between the byte
// front end and the word sequencer has room; each completed word or end
// command occupies one queue entry until the sequencer picks it up, and the
// sequencer holds one job while it works through its words.
// When the receiver stalls, the sequencer holds its output register and the
// queue fills, after which in_ready drops until words drain.
// Reset clears the byte position, the bit count, the queue and the output
// valid flag; the block is then ready for a new message.
module sha512_message_padder_unit
    import smp_pkg::*;
#(
    parameter int QDEPTH = SMP_QDEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] word,
    output logic [3:0]  word_index,
    output logic        block_done,
    output logic        message_done,
    output logic        last
);

    logic     q_full;
    logic     q_empty;
    logic     push_valid;
    logic     pop;
    smp_job_t push_job;
    smp_job_t pop_job;

    smp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .data_byte  (data_byte),
        .q_full     (q_full),
        .push_valid (push_valid),
        .push_job   (push_job)
    );

    smp_queue #(
        .QDEPTH (QDEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .pop_job    (pop_job),
        .empty      (q_empty)
    );

    smp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_job        (pop_job),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .word         (word),
        .word_index   (word_index),
        .block_done   (block_done),
        .message_done (message_done),
        .last         (last)
    );

endmodule

>>> test/sha512_pad_checker.sv
`timescale 1ns / 1ps

module sha512_pad_checker
    import smp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        cmd,
    input  logic [7:0]  data_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [63:0] word,
    input  logic [3:0]  word_index,
    input  logic        block_done,
    input  logic        message_done,
    input  logic        last,
    output int          error_count,
    output int          words_pending,
    output int          words_checked
);

    localparam logic [6:0] LENGTH_FIELD_POS = 7'd112;

    typedef struct packed {
        logic [63:0] word;
        logic [3:0]  index;
        logic        block_done;
        logic        message_done;
        logic        last;
    } block_word_t;

    block_word_t expected_words[$];
    logic [55:0] gather;
    logic [6:0]  block_pos;
    logic [63:0] msg_bits;

    task automatic push_word(input logic [63:0] w, input logic [3:0] idx,
                             input logic msg_end, input logic lst);
        block_word_t bw;
        bw.word = w;
        bw.index = idx;
        bw.block_done = (idx == SMP_LAST_IDX);
        bw.message_done = msg_end;
        bw.last = lst;
        expected_words.push_back(bw);
    endtask

    task automatic predict_words(input logic c, input logic [7:0] b);
        int          k;
        int          first;
        logic        fits;
        logic [63:0] w;
        logic [63:0] v;
        logic        fin;
        if (c == SMP_CMD_BYTE)
        begin
            msg_bits = msg_bits + 64'd8;
            if (block_pos[2:0] == 3'd7)
            begin
                push_word({gather, b}, block_pos[6:3], 1'b0, 1'b1);
                gather = '0;
            end
            else
            begin
                gather = {gather[47:0], b};
            end
            block_pos = block_pos + 7'd1;
        end
        else
        begin
            k = block_pos[2:0];
            first = block_pos[6:3];
            fits = (block_pos < LENGTH_FIELD_POS);
            if (k == 0)
                w = {SMP_PAD_BYTE, 56'h0};
            else
                w = ({8'h00, gather} << (64 - 8 * k)) | ({SMP_PAD_BYTE, 56'h0} >> (8 * k));
            for (int i = first; i < 16; i++)
            begin
                v = (i == first) ? w : 64'h0;
                fin = fits && (i == 15);
                if (fin)
                    v = msg_bits;
                push_word(v, i[3:0], fin, fin);
            end
            if (!fits)
            begin
                for (int i = 0; i < 16; i++)
                    push_word((i == 15) ? msg_bits : 64'h0, i[3:0], i == 15, i == 15);
            end
            gather = '0;
            block_pos = '0;
            msg_bits = '0;
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_val,
                               input logic [63:0] act_val);
        if (act_val !== exp_val)
        begin
            $error("%s: expected %h, got %h", name, exp_val, act_val);
            error_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        block_word_t bw;
        if (!rst_n)
        begin
            gather = '0;
            block_pos = '0;
            msg_bits = '0;
            error_count = 0;
            words_checked = 0;
            expected_words.delete();
            words_pending <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_words(cmd, data_byte);
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("unexpected word %h at index %0d", word, word_index);
                    error_count++;
                end
                else
                begin
                    bw = expected_words.pop_front();
                    check_field("word", bw.word, word);
                    check_field("word_index", bw.index, word_index);
                    check_field("block_done", bw.block_done, block_done);
                    check_field("message_done", bw.message_done, message_done);
                    check_field("last", bw.last, last);
                    words_checked++;
                end
            end
            words_pending <= expected_words.size();
        end
    end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top
    import smp_pkg::*;
;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_ITEMS = 88;
    localparam int TAIL_CYCLES = 60;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        cmd = SMP_CMD_BYTE;
    logic [7:0]  data_byte = 8'h00;
    logic        out_ready = 1'b0;
    logic        in_ready;
    logic        out_valid;
    logic [63:0] word;
    logic [3:0]  word_index;
    logic        block_done;
    logic        message_done;
    logic        last;

    int error_count;
    int words_pending;
    int words_checked;
    int idle_cycles = 0;
    int ready_hold = 0;
    int messages_sent = 0;
    int bytes_sent = 0;
    int two_block_pads = 0;
    int fill_pos = 0;
    bit no_gaps = 1'b0;

    sha512_message_padder_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .word         (word),
        .word_index   (word_index),
        .block_done   (block_done),
        .message_done (message_done),
        .last         (last)
    );

    sha512_pad_checker pad_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .data_byte     (data_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .word          (word),
        .word_index    (word_index),
        .block_done    (block_done),
        .message_done  (message_done),
        .last          (last),
        .error_count   (error_count),
        .words_pending (words_pending),
        .words_checked (words_checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 8);
        else
            return $urandom_range(15, 40);
    endfunction

    function automatic int pick_stall();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        else
            return $urandom_range(0, 2);
    endfunction

    function automatic int pick_ready_run();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(60, 150);
        else
            return $urandom_range(0, 30);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            ready_hold <= 0;
        end
        else if (ready_hold > 0)
        begin
            ready_hold <= ready_hold - 1;
        end
        else if (out_ready)
        begin
            out_ready <= 1'b0;
            ready_hold <= pick_stall();
        end
        else
        begin
            out_ready <= 1'b1;
            ready_hold <= pick_ready_run();
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    task automatic send_item(input logic c, input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        data_byte <= b;
        do
            @(posedge clk);
        while (!in_ready);
        if (c == SMP_CMD_END)
        begin
            messages_sent++;
            if (fill_pos >= 112)
                two_block_pads++;
            fill_pos = 0;
        end
        else
        begin
            bytes_sent++;
            fill_pos = (fill_pos + 1) % 128;
        end
    endtask

    task automatic send_message(input int len);
        no_gaps = ($urandom_range(0, 3) == 0);
        repeat (len) send_item(SMP_CMD_BYTE, 8'($urandom_range(0, 255)));
        send_item(SMP_CMD_END, 8'($urandom_range(0, 255)));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (words_pending != 0);
    endtask

    initial
    begin
        int len;
        int msg_no;
        int random_items;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(SMP_CMD_END, 8'hA5);
        repeat (8) send_item(SMP_CMD_BYTE, 8'hFF);
        send_item(SMP_CMD_END, 8'h00);
        send_item(SMP_CMD_BYTE, 8'h00);
        send_item(SMP_CMD_BYTE, 8'h80);
        send_item(SMP_CMD_BYTE, 8'hFF);
        send_item(SMP_CMD_END, 8'hFF);
        for (int i = 1; i <= 7; i++)
            send_item(SMP_CMD_BYTE, 8'(i * 8'h21));
        send_item(SMP_CMD_END, 8'h5A);
        send_item(SMP_CMD_END, 8'h00);

        wait_drained();

        msg_no = 0;
        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            if (msg_no == 0)
                len = $urandom_range(112, 119);
            else if ($urandom_range(0, 9) == 0)
                len = $urandom_range(24, 64);
            else
                len = $urandom_range(0, 23);
            send_message(len);
            random_items += len + 1;
            msg_no++;
            if ($urandom_range(0, 7) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d messages with %0d bytes in total, %0d of them padded over two blocks.",
                 messages_sent, bytes_sent, two_block_pads);
        $display("Checked %0d block words against the predicted padding.", words_checked);
        if (error_count == 0 && words_pending == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

>>> sim.f
sv/smp_pkg.sv
sv/smp_front.sv
sv/smp_queue.sv
sv/smp_back.sv
sv/sha512_message_padder_unit.sv
test/sha512_pad_checker.sv
test/tb_top.sv
